// ===== rtl/integer_pixel_upscaler_macros.svh =====
// Assertion shorthands for the upscaler. Every check samples on the rising
// clock edge and is switched off while reset is high.
`ifndef INTEGER_PIXEL_UPSCALER_MACROS_SVH
`define INTEGER_PIXEL_UPSCALER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold at a later sample than the antecedent.
`define IPU_ASSERT_AFTER2(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##2 (cons)) \
      else $error(msg);

`endif

// ===== rtl/ipu_pkg.sv =====
package ipu_pkg;

   // Frame store geometry.
   localparam int MAX_PIXELS = 4096;
   localparam int ADDR_W     = $clog2(MAX_PIXELS);

   // Field and register widths.
   localparam int PIXEL_W    = 16;
   localparam int DIM_W      = 13;
   localparam int SCALE_W    = 8;
   localparam int ROT_W      = 3;
   localparam int AREA_W     = 2 * DIM_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = DIM_W;

   // Rotation bit that swaps width and height.
   localparam int ROT_SWAP_BIT = 1;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCALE    = 2'd0,
      CSR_WIDTH    = 2'd1,
      CSR_HEIGHT   = 2'd2,
      CSR_ROTATION = 2'd3
   } csr_index_type;

   // Request operation codes.
   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_PULL = 1'b1
   } op_type;

   // Effective frame geometry after the rotation swap.
   typedef struct packed {
      logic               enabled;
      logic [SCALE_W-1:0] scale;
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
   } geom_type;

   // One write into the frame store.
   typedef struct packed {
      logic               en;
      logic [ADDR_W-1:0]  addr;
      logic [PIXEL_W-1:0] data;
   } store_wr_type;

   // A pull beat on its way to the address stage.
   typedef struct packed {
      logic             valid;
      logic             last;
      logic [DIM_W-1:0] row;
      logic [DIM_W-1:0] col;
      logic [DIM_W-1:0] width;
   } pull_beat_type;

endpackage

// ===== rtl/integer_pixel_upscaler.sv =====
// Nearest-neighbour integer upscaler. One beat is taken on every clock at which
// start is high; busy stays low, so loads and pulls may follow each other with
// no gaps. A load writes its pixel into the 4096-entry frame store in that same
// cycle. A pull whose output is enabled produces its result after the scan
// position is registered and then the row-times-width address multiply and
// the registered frame store read. The result is shown for exactly one cycle
// under rsp_valid and cannot be held off by the receiver. A pull with scale,
// width or height at zero gives no result. The frame store needs no clearing
// after reset; pixels must be loaded before they are pulled. The user must
// write configuration through the csr_ port only while no pull is still in
// flight; the block itself does not enforce this.
`include "integer_pixel_upscaler_macros.svh"

module integer_pixel_upscaler
   import ipu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_op,
   input  logic [PIXEL_W-1:0]    req_pixel_in,
   output logic                  rsp_valid,
   output logic [PIXEL_W-1:0]    rsp_pixel_out,
   output logic                  rsp_frame_last,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [DIM_W-1:0]   width_ff, width_in, height_ff, height_in;
   logic [ROT_W-1:0]   rot_ff, rot_in;
   logic               rsp_valid_ff, rsp_last_ff, rsp_in_range_ff;

   geom_type           geom;
   store_wr_type       store_wr;
   pull_beat_type      beat;
   logic               load_accept, pull_accept;
   logic [AREA_W-1:0]  pos;
   logic               pos_in_range;
   logic [PIXEL_W-1:0] rd_data;

   // The block never stalls a request.
   assign busy        = 1'b0;
   assign load_accept = start && !busy && (op_type'(req_op) == OP_LOAD);
   assign pull_accept = start && !busy && (op_type'(req_op) == OP_PULL);

   // Register write decode.
   always_comb begin
      scale_in  = scale_ff;
      width_in  = width_ff;
      height_in = height_ff;
      rot_in    = rot_ff;
      unique case (csr_index_type'(csr_index))
         CSR_SCALE:    scale_in  = csr_wdata[SCALE_W-1:0];
         CSR_WIDTH:    width_in  = csr_wdata[DIM_W-1:0];
         CSR_HEIGHT:   height_in = csr_wdata[DIM_W-1:0];
         CSR_ROTATION: rot_in    = csr_wdata[ROT_W-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= SCALE_W'(1);
         width_ff  <= '0;
         height_ff <= '0;
         rot_ff    <= '0;
      end else if (csr_write_en) begin
         scale_ff  <= scale_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         rot_ff    <= rot_in;
      end
   end

   // Effective geometry after the rotation swap.
   always_comb begin
      geom.scale   = scale_ff;
      geom.width   = rot_ff[ROT_SWAP_BIT] ? height_ff : width_ff;
      geom.height  = rot_ff[ROT_SWAP_BIT] ? width_ff : height_ff;
      geom.enabled = (scale_ff != '0) && (width_ff != '0) && (height_ff != '0);
   end

   ipu_scan_ctrl u_scan_ctrl (
      .clock       (clock),
      .reset       (reset),
      .load_accept (load_accept),
      .pull_accept (pull_accept),
      .pixel_in    (req_pixel_in),
      .geom        (geom),
      .store_wr    (store_wr),
      .beat        (beat)
   );

   // Address stage: row-major position of the source pixel.
   assign pos = AREA_W'(beat.row) * AREA_W'(beat.width) + AREA_W'(beat.col);
   assign pos_in_range = pos < AREA_W'(MAX_PIXELS);

   ipu_frame_store u_frame_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd_en   (beat.valid),
      .rd_addr (pos[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Result stage, alongside the registered store read.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= beat.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_last_ff     <= beat.last;
      rsp_in_range_ff <= pos_in_range;
   end

   // Positions beyond the store read as zero.
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_in_range_ff ? rd_data : '0;
   assign rsp_frame_last = rsp_last_ff;

   // An enabled pull always yields exactly one result beat, through the beat and result registers.
   `IPU_ASSERT_AFTER2(a_pull_gives_beat, pull_accept && geom.enabled, rsp_valid, "enabled pull lost its result")
   // Every result beat traces back to an accepted pull.
   `IPU_ASSERT_NOW(a_beat_has_pull, rsp_valid, $past(pull_accept, 2), "result beat without a pull")
   // A load never produces a result beat.
   `IPU_ASSERT_AFTER2(a_load_is_silent, load_accept, !rsp_valid, "load produced a result beat")

endmodule

// ===== rtl/ipu_frame_store.sv =====
module ipu_frame_store
   import ipu_pkg::*;
(
   input  logic               clock,
   input  store_wr_type       wr,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [PIXEL_W-1:0] rd_data
);

   logic [PIXEL_W-1:0] store_mem [MAX_PIXELS];
   logic [PIXEL_W-1:0] rd_data_ff;

   // Single write port and one registered read port. A read and a write at the
   // same edge return the old contents.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ipu_scan_ctrl.sv =====
module ipu_scan_ctrl
   import ipu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               load_accept,
   input  logic               pull_accept,
   input  logic [PIXEL_W-1:0] pixel_in,
   input  geom_type           geom,
   output store_wr_type       store_wr,
   output pull_beat_type      beat
);

   logic [AREA_W-1:0]  load_idx_ff, load_idx_in;
   logic [DIM_W-1:0]   row_ff, row_in, col_ff, col_in;
   logic [SCALE_W-1:0] row_rep_ff, row_rep_in, col_rep_ff, col_rep_in;
   pull_beat_type      beat_ff, beat_in;

   logic [AREA_W-1:0]  area;
   logic [AREA_W:0]    load_idx_inc;
   logic [DIM_W-1:0]   row_c, col_c;
   logic [SCALE_W-1:0] row_rep_c, col_rep_c;
   logic [SCALE_W:0]   row_rep_inc, col_rep_inc;
   logic [DIM_W:0]     row_inc, col_inc;
   logic               col_rep_wrap, col_wrap, row_rep_wrap, row_wrap;
   logic               pull_go;

   // Load pointer: wraps after the last pixel of the frame, and loads past the
   // store capacity are dropped while the pointer still moves on.
   always_comb begin
      area         = AREA_W'(geom.width) * AREA_W'(geom.height);
      load_idx_inc = {1'b0, load_idx_ff} + (AREA_W+1)'(1);
      if (load_idx_inc >= {1'b0, area}) begin
         load_idx_in = '0;
      end else begin
         load_idx_in = load_idx_inc[AREA_W-1:0];
      end
      store_wr.en   = load_accept && (load_idx_ff < AREA_W'(MAX_PIXELS));
      store_wr.addr = load_idx_ff[ADDR_W-1:0];
      store_wr.data = pixel_in;
   end

   // Output position: counters left beyond a new limit are pulled back to the
   // last value, then the column repeat, column, row repeat and row advance.
   always_comb begin
      pull_go   = pull_accept && geom.enabled;
      row_c     = (row_ff >= geom.height) ? geom.height - DIM_W'(1) : row_ff;
      col_c     = (col_ff >= geom.width) ? geom.width - DIM_W'(1) : col_ff;
      row_rep_c = (row_rep_ff >= geom.scale) ? geom.scale - SCALE_W'(1) : row_rep_ff;
      col_rep_c = (col_rep_ff >= geom.scale) ? geom.scale - SCALE_W'(1) : col_rep_ff;

      row_inc     = {1'b0, row_c} + (DIM_W+1)'(1);
      col_inc     = {1'b0, col_c} + (DIM_W+1)'(1);
      row_rep_inc = {1'b0, row_rep_c} + (SCALE_W+1)'(1);
      col_rep_inc = {1'b0, col_rep_c} + (SCALE_W+1)'(1);

      col_rep_wrap = col_rep_inc >= {1'b0, geom.scale};
      col_wrap     = col_rep_wrap && (col_inc >= {1'b0, geom.width});
      row_rep_wrap = col_wrap && (row_rep_inc >= {1'b0, geom.scale});
      row_wrap     = row_rep_wrap && (row_inc >= {1'b0, geom.height});

      col_rep_in = col_rep_wrap ? '0 : col_rep_inc[SCALE_W-1:0];
      col_in     = col_rep_wrap ? (col_wrap ? '0 : col_inc[DIM_W-1:0]) : col_c;
      row_rep_in = col_wrap ? (row_rep_wrap ? '0 : row_rep_inc[SCALE_W-1:0]) : row_rep_c;
      row_in     = row_rep_wrap ? (row_wrap ? '0 : row_inc[DIM_W-1:0]) : row_c;

      beat_in.valid = pull_go;
      beat_in.last  = row_wrap;
      beat_in.row   = row_c;
      beat_in.col   = col_c;
      beat_in.width = geom.width;
   end

   // Pointer and counter registers. The beat payload needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         load_idx_ff   <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         row_rep_ff    <= '0;
         col_rep_ff    <= '0;
         beat_ff.valid <= 1'b0;
      end else begin
         if (load_accept) begin
            load_idx_ff <= load_idx_in;
         end
         if (pull_go) begin
            row_ff     <= row_in;
            col_ff     <= col_in;
            row_rep_ff <= row_rep_in;
            col_rep_ff <= col_rep_in;
         end
         beat_ff.valid <= beat_in.valid;
      end
      beat_ff.last  <= beat_in.last;
      beat_ff.row   <= beat_in.row;
      beat_ff.col   <= beat_in.col;
      beat_ff.width <= beat_in.width;
   end

   assign beat = beat_ff;

endmodule
